[design/sis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the sorted interval set
// Table depth, index widths and command codes.
// ----------------------------------------------------------------------------
package sis_pkg;
	localparam int MaxRanges = 16;
	localparam int IdxW = $clog2(MaxRanges);
	localparam int CntW = $clog2(MaxRanges + 1);
	localparam int OutCntW = 5;

	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef logic signed [31:0] idx_t;
	typedef logic [2*32-1:0] entry_t;
endpackage

[design/sorted_interval_set.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_set: bounded ascending table of disjoint index ranges
// Each command scans the stored ranges in order, then writes back and shifts
// entries on a grow, insert or merge. A new item cannot be taken until the last
// is through: busy is high from acceptance until the result strobe, and a new
// item is taken as it ends. Results cannot be stalled. Reset empties the table;
// entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_interval_set import sis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic signed [31:0]  index_value,
	output logic                valid,
	output logic                was_present,
	output logic                table_full,
	output logic [OutCntW-1:0]  range_count
);
	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CMP, S_OPEN_RD, S_OPEN_WR, S_CLOSE_RD, S_CLOSE_WR
	} state_t;

	entry_t mem [MaxRanges];
	entry_t rdata_q;
	logic mem_we;
	logic [IdxW-1:0] mem_wa, mem_ra;
	entry_t mem_wd;

	state_t state_q;
	logic [CntW-1:0] used_q, k_q, j_q;
	logic cmd_q;
	idx_t v_q;
	logic signed [32:0] prev_hi_q;
	idx_t prev_lo_q;
	logic prev_ok_q;
	entry_t new_q;
	logic merge_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	logic signed [32:0] lo, hi, vx;
	assign lo = {rdata_q[63], rdata_q[63:32]};
	assign hi = {rdata_q[31], rdata_q[31:0]};
	assign vx = {v_q[31], v_q};

	always_comb begin
		mem_we = 1'b0;
		mem_wa = k_q[IdxW-1:0];
		mem_wd = new_q;
		mem_ra = k_q[IdxW-1:0];
		unique case (state_q)
			S_OPEN_RD: mem_ra = IdxW'(j_q - CntW'(1));
			S_OPEN_WR: begin
				mem_we = 1'b1;
				mem_wa = j_q[IdxW-1:0];
				mem_wd = (j_q == k_q) ? new_q : rdata_q;
			end
			S_CLOSE_RD: mem_ra = IdxW'(j_q + CntW'(1));
			S_CLOSE_WR: begin
				mem_we = 1'b1;
				mem_wa = j_q[IdxW-1:0];
				mem_wd = rdata_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			valid <= 1'b0;
			was_present <= 1'b0;
			table_full <= 1'b0;
			range_count <= '0;
			k_q <= '0;
			j_q <= '0;
			cmd_q <= 1'b0;
			v_q <= '0;
			prev_hi_q <= '0;
			prev_lo_q <= '0;
			prev_ok_q <= 1'b0;
			new_q <= '0;
		end else begin
			valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						v_q <= index_value;
						k_q <= '0;
						prev_ok_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (k_q < used_q && hi < vx) begin
						prev_hi_q <= hi;
						prev_lo_q <= rdata_q[63:32];
						prev_ok_q <= 1'b1;
						k_q <= k_q + CntW'(1);
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
						valid <= 1'b1;
						was_present <= 1'b0;
						table_full <= 1'b0;
						range_count <= OutCntW'(used_q);
						if (k_q < used_q && lo <= vx) begin
							was_present <= 1'b1;
						end else if (cmd_q == CMD_ADD) begin
							if (prev_ok_q && prev_hi_q + 33'sd1 == vx) begin
								if (k_q < used_q && lo == vx + 33'sd1)
									new_q <= {prev_lo_q, rdata_q[31:0]};
								else
									new_q <= {prev_lo_q, v_q};
								k_q <= k_q - CntW'(1);
								j_q <= k_q - CntW'(1);
								valid <= 1'b0;
								state_q <= S_OPEN_WR;
							end else if (k_q < used_q && lo - 33'sd1 == vx) begin
								new_q <= {v_q, rdata_q[31:0]};
								j_q <= k_q;
								valid <= 1'b0;
								state_q <= S_OPEN_WR;
							end else if (used_q >= CntW'(MaxRanges)) begin
								table_full <= 1'b1;
							end else begin
								new_q <= {v_q, v_q};
								used_q <= used_q + CntW'(1);
								range_count <= OutCntW'(used_q + CntW'(1));
								j_q <= used_q;
								valid <= 1'b0;
								if (used_q == k_q) state_q <= S_OPEN_WR;
								else state_q <= S_OPEN_RD;
							end
						end
					end
				end
				S_OPEN_RD: begin
					state_q <= S_OPEN_WR;
				end
				S_OPEN_WR: begin
					if (j_q == k_q) begin
						if (merge_q) begin
							j_q <= k_q + CntW'(1);
							state_q <= (k_q + CntW'(2) < used_q) ? S_CLOSE_RD : S_IDLE;
							valid <= !(k_q + CntW'(2) < used_q);
							if (!(k_q + CntW'(2) < used_q)) begin
								used_q <= used_q - CntW'(1);
								range_count <= OutCntW'(used_q - CntW'(1));
								was_present <= 1'b0;
								table_full <= 1'b0;
							end
						end else begin
							state_q <= S_IDLE;
							valid <= 1'b1;
							was_present <= 1'b0;
							table_full <= 1'b0;
							range_count <= OutCntW'(used_q);
						end
					end else begin
						j_q <= j_q - CntW'(1);
						state_q <= (j_q - CntW'(1) == k_q) ? S_OPEN_WR : S_OPEN_RD;
					end
				end
				S_CLOSE_RD: state_q <= S_CLOSE_WR;
				S_CLOSE_WR: begin
					if (j_q + CntW'(2) < used_q) begin
						j_q <= j_q + CntW'(1);
						state_q <= S_CLOSE_RD;
					end else begin
						used_q <= used_q - CntW'(1);
						range_count <= OutCntW'(used_q - CntW'(1));
						was_present <= 1'b0;
						table_full <= 1'b0;
						valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) merge_q <= 1'b0;
		else if (state_q == S_CMP) merge_q <= k_q < used_q
			&& prev_ok_q && prev_hi_q + 33'sd1 == vx && lo == vx + 33'sd1;
	end

	assert property (@(posedge clk) disable iff (!arst_n) used_q <= CntW'(MaxRanges))
		else $error("range count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) valid |-> !table_full || !was_present)
		else $error("full and present together");
	assert property (@(posedge clk) disable iff (!arst_n) valid |=> !valid)
		else $error("double strobe");
endmodule
